// File: src/midpoint_ellipse_rasterizer_top_macros.svh
// assertion macros used by the checker file of the ellipse rasterizer
// no dependencies; include by bare file name
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_MACROS_SVH

// property checked on the rising clock, skipped while reset is high
`define MER_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock, reset included
`define MER_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/mer_pkg.sv
// shared types and constants of the midpoint ellipse rasterizer
// no dependencies
package mer_pkg;

   localparam int RADIUS_BITS_DEF = 10;
   localparam int COORD_BITS_DEF  = 12;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] QUAD_FIRST = 2'd0;
   localparam logic [1:0] QUAD_LAST  = 2'd3;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      logic         valid;
      cmd_kind_type kind;
   } cmd_ctl_type;

   typedef enum logic [1:0] {
      PH_DONE = 2'd0,
      PH_R1   = 2'd1,
      PH_R2   = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START_RX,
      ST_START_RY,
      ST_START_GRAD,
      ST_START_DEC,
      ST_SW_TX,
      ST_SW_TY,
      ST_SW_MUL_RY,
      ST_SW_MUL_RX,
      ST_SW_MUL_RR,
      ST_SW_DEC,
      ST_EMIT,
      ST_DONE_OUT,
      ST_ADVANCE
   } eng_state_type;

endpackage

// File: src/mer_ifs.sv
// request and response channel interfaces of the ellipse rasterizer
// depends on mer_pkg for default widths
interface mer_req_if import mer_pkg::*; #(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic        [RADIUS_BITS-1:0] radius_x;
   logic        [RADIUS_BITS-1:0] radius_y;
   logic signed [COORD_BITS-1:0]  center_x;
   logic signed [COORD_BITS-1:0]  center_y;

   modport source (output valid, command, radius_x, radius_y, center_x, center_y,
                   input ready);
   modport sink (input valid, command, radius_x, radius_y, center_x, center_y,
                 output ready);
endinterface

interface mer_rsp_if import mer_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic signed [COORD_BITS:0] point_x;
   logic signed [COORD_BITS:0] point_y;
   logic        [1:0]          quadrant;
   logic                       last_of_step;
   logic                       done_res;

   modport source (output valid, point_x, point_y, quadrant, last_of_step, done_res,
                   input ready);
   modport sink (input valid, point_x, point_y, quadrant, last_of_step, done_res,
                 output ready);
endinterface

// File: src/midpoint_ellipse_rasterizer_top.sv
// top level of the midpoint ellipse rasterizer
// depends on mer_pkg, mer_ifs, mer_front and mer_back
//
//   channel    dir  handshake        payload
//   req_chan   in   valid / ready    command, radius_x, radius_y, center_x, center_y
//   rsp_chan   out  valid / ready    point_x, point_y, quadrant, last_of_step, done_res
//
// a start runs START_RX, START_RY and START_GRAD on the shared multiplier, then
// START_DEC; a step runs decode, four point transfers, one decision update
// the step that crosses into region 2 first runs the multiplier sequence SW_TX to SW_DEC
// a step on a finished outline gives its done result from DONE_OUT once the result register is free
// reset clears control state synchronously, no clearing pass
// a two-entry command queue keeps requests flowing while the result register stalls
module midpoint_ellipse_rasterizer_top import mer_pkg::*; #(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mer_req_if.sink   req_chan,
   mer_rsp_if.source rsp_chan
);

   // head of the command queue as seen by the engine
   cmd_ctl_type                   head_ctl;
   logic        [RADIUS_BITS-1:0] head_rx;
   logic        [RADIUS_BITS-1:0] head_ry;
   logic signed [COORD_BITS-1:0]  head_cx;
   logic signed [COORD_BITS-1:0]  head_cy;
   // engine has consumed the head command
   logic                          pop;

   // front: accepts every transfer while the queue has room
   mer_front #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .head_ctl (head_ctl),
      .head_rx  (head_rx),
      .head_ry  (head_ry),
      .head_cx  (head_cx),
      .head_cy  (head_cy)
   );

   // back: setup, region switch, point emission and decision updates
   mer_back #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head_ctl (head_ctl),
      .head_rx  (head_rx),
      .head_ry  (head_ry),
      .head_cx  (head_cx),
      .head_cy  (head_cy),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: src/mer_front.sv
// front part: accepts requests, classifies them and queues them for the engine
// depends on mer_pkg and mer_req_if
module mer_front import mer_pkg::*; #(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   mer_req_if.sink                      req_chan,
   input  logic                         pop,
   output cmd_ctl_type                  head_ctl,
   output logic        [RADIUS_BITS-1:0] head_rx,
   output logic        [RADIUS_BITS-1:0] head_ry,
   output logic signed [COORD_BITS-1:0]  head_cx,
   output logic signed [COORD_BITS-1:0]  head_cy
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_kind_type                kind_ff [QUEUE_DEPTH];
   logic        [RADIUS_BITS-1:0] rx_ff   [QUEUE_DEPTH];
   logic        [RADIUS_BITS-1:0] ry_ff   [QUEUE_DEPTH];
   logic signed [COORD_BITS-1:0]  cx_ff   [QUEUE_DEPTH];
   logic signed [COORD_BITS-1:0]  cy_ff   [QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign req_chan.ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         kind_ff[wr_ptr_ff] <= req_chan.command ? CMD_STEP : CMD_START;
         rx_ff[wr_ptr_ff]   <= req_chan.radius_x;
         ry_ff[wr_ptr_ff]   <= req_chan.radius_y;
         cx_ff[wr_ptr_ff]   <= req_chan.center_x;
         cy_ff[wr_ptr_ff]   <= req_chan.center_y;
      end
   end

   assign head_ctl.valid = (count_ff != '0);
   assign head_ctl.kind  = kind_ff[rd_ptr_ff];
   assign head_rx        = rx_ff[rd_ptr_ff];
   assign head_ry        = ry_ff[rd_ptr_ff];
   assign head_cx        = cx_ff[rd_ptr_ff];
   assign head_cy        = cy_ff[rd_ptr_ff];

endmodule

// File: src/mer_back.sv
// back part: setup sequencer, shared multiplier, point emitter and updates
// depends on mer_pkg and mer_rsp_if
module mer_back import mer_pkg::*; #(
   parameter int RADIUS_BITS = RADIUS_BITS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_ctl_type                   head_ctl,
   input  logic        [RADIUS_BITS-1:0] head_rx,
   input  logic        [RADIUS_BITS-1:0] head_ry,
   input  logic signed [COORD_BITS-1:0]  head_cx,
   input  logic signed [COORD_BITS-1:0]  head_cy,
   output logic                          pop,
   mer_rsp_if.source                     rsp_chan
);

   localparam int R   = RADIUS_BITS;
   localparam int C   = COORD_BITS;
   localparam int PXW = R + 2;
   localparam int GW  = 3 * R + 3;
   localparam int DW  = (4 * R + 6 > 64) ? 64 : 4 * R + 6;
   localparam int MA  = 2 * R;
   localparam int MB  = 2 * R + 4;
   localparam int PW  = MA + MB;
   localparam int XW  = (PW > DW) ? PW : DW;
   localparam int SW  = ((PXW > C) ? PXW : C) + 1;
   localparam int OW  = C + 1;

   eng_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;

   logic signed [PXW-1:0] pos_x_ff, pos_x_in;
   logic signed [PXW-1:0] pos_y_ff, pos_y_in;
   logic signed [GW-1:0]  grad_x_ff, grad_x_in;
   logic signed [GW-1:0]  grad_y_ff, grad_y_in;
   logic        [DW-1:0]  dec_ff, dec_in;
   logic        [MA-1:0]  rx2_ff, rx2_in;
   logic        [MA-1:0]  ry2_ff, ry2_in;
   logic signed [C-1:0]   cx_ff, cx_in;
   logic signed [C-1:0]   cy_ff, cy_in;
   logic        [MB-1:0]  tmp_ff, tmp_in;
   logic        [PW-1:0]  prod_ff, prod_in;
   logic        [1:0]     quad_ff, quad_in;
   logic                  use_gx_ff, use_gx_in;
   logic                  use_gy_ff, use_gy_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic        [OW-1:0]  point_x_ff, point_x_in;
   logic        [OW-1:0]  point_y_ff, point_y_in;
   logic        [1:0]     quad_out_ff, quad_out_in;
   logic                  last_ff, last_in;
   logic                  done_ff, done_in;

   logic          [MA-1:0] mul_a;
   logic          [MB-1:0] mul_b;
   logic          [XW-1:0] prod_x;
   logic          [R+1:0]  tx_c;
   logic signed [PXW-1:0]  ty_c;
   logic          [PXW-1:0] ty_abs;
   logic                   slot_free, need_switch, outline_ends, r1;
   logic                   dec_neg, dec_pos, step_x, step_y;
   logic                   load_point, load_done;
   logic          [DW-1:0] gx_ext, gy_ext, adv_term;
   logic signed [SW-1:0]   px_ext, py_ext, px_sum, py_sum;

   assign slot_free    = !rsp_valid_ff || rsp_chan.ready;
   assign need_switch  = (phase_ff == PH_R1) && !(grad_x_ff < grad_y_ff);
   assign outline_ends = (phase_ff == PH_R2) && pos_y_ff[PXW-1];
   assign r1           = (phase_ff == PH_R1);
   assign dec_neg      = dec_ff[DW-1];
   assign dec_pos      = (dec_ff != '0) && !dec_neg;
   assign step_x       = r1 || !dec_pos;
   assign step_y       = !r1 || !dec_neg;

   assign tx_c   = {pos_x_ff[R:0], 1'b1};
   assign ty_c   = pos_y_ff - PXW'(1);
   assign ty_abs = ty_c[PXW-1] ? PXW'(-ty_c) : PXW'(ty_c);
   assign prod_x = XW'(prod_ff);

   assign gx_ext   = DW'(grad_x_ff);
   assign gy_ext   = DW'(grad_y_ff);
   assign adv_term = (use_gx_ff ? gx_ext : '0) - (use_gy_ff ? gy_ext : '0)
                     + (r1 ? DW'(ry2_ff) : DW'(rx2_ff));

   // symmetric point for the current quadrant
   assign px_ext = quad_ff[0] ? -SW'(pos_x_ff) : SW'(pos_x_ff);
   assign py_ext = quad_ff[1] ? -SW'(pos_y_ff) : SW'(pos_y_ff);
   assign px_sum = px_ext + SW'(cx_ff);
   assign py_sum = py_ext + SW'(cy_ff);

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_START_RX: begin
            mul_a = MA'(head_rx);
            mul_b = MB'(head_rx);
         end
         ST_START_RY: begin
            mul_a = MA'(pos_y_ff[R-1:0]);
            mul_b = MB'(pos_y_ff[R-1:0]);
         end
         ST_START_GRAD: begin
            mul_a = rx2_ff;
            mul_b = MB'(pos_y_ff[R-1:0]);
         end
         ST_SW_TX: begin
            mul_a = MA'(tx_c);
            mul_b = MB'(tx_c);
         end
         ST_SW_TY: begin
            mul_a = MA'(ty_abs);
            mul_b = MB'(ty_abs);
         end
         ST_SW_MUL_RY: begin
            mul_a = ry2_ff;
            mul_b = tmp_ff;
         end
         ST_SW_MUL_RX: begin
            mul_a = rx2_ff;
            mul_b = tmp_ff;
         end
         ST_SW_MUL_RR: begin
            mul_a = rx2_ff;
            mul_b = MB'(ry2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_ctl.valid) begin
               if (head_ctl.kind == CMD_START) begin
                  state_in = ST_START_RX;
               end else if (need_switch) begin
                  state_in = ST_SW_TX;
               end else if (phase_ff == PH_DONE || outline_ends) begin
                  state_in = ST_DONE_OUT;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_START_RX:   state_in = ST_START_RY;
         ST_START_RY:   state_in = ST_START_GRAD;
         ST_START_GRAD: state_in = ST_START_DEC;
         ST_START_DEC:  state_in = ST_IDLE;
         ST_SW_TX:      state_in = ST_SW_TY;
         ST_SW_TY:      state_in = ST_SW_MUL_RY;
         ST_SW_MUL_RY:  state_in = ST_SW_MUL_RX;
         ST_SW_MUL_RX:  state_in = ST_SW_MUL_RR;
         ST_SW_MUL_RR:  state_in = ST_SW_DEC;
         ST_SW_DEC:     state_in = ST_IDLE;
         ST_EMIT: begin
            if (slot_free && quad_ff == QUAD_LAST) begin
               state_in = ST_ADVANCE;
            end
         end
         ST_DONE_OUT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_ADVANCE:    state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath controls and next values
   always_comb begin
      phase_in   = phase_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      grad_x_in  = grad_x_ff;
      grad_y_in  = grad_y_ff;
      dec_in     = dec_ff;
      rx2_in     = rx2_ff;
      ry2_in     = ry2_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      tmp_in     = tmp_ff;
      quad_in    = quad_ff;
      use_gx_in  = use_gx_ff;
      use_gy_in  = use_gy_ff;
      pop        = 1'b0;
      load_point = 1'b0;
      load_done  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head_ctl.valid && head_ctl.kind == CMD_STEP && !need_switch) begin
               pop     = 1'b1;
               quad_in = QUAD_FIRST;
               if (outline_ends) begin
                  phase_in = PH_DONE;
               end
            end
         end
         ST_START_RX: begin
            pop       = 1'b1;
            pos_x_in  = '0;
            pos_y_in  = PXW'(head_ry);
            grad_x_in = '0;
            cx_in     = head_cx;
            cy_in     = head_cy;
            phase_in  = PH_R1;
         end
         ST_START_RY: begin
            rx2_in = prod_ff[MA-1:0];
         end
         ST_START_GRAD: begin
            ry2_in = prod_ff[MA-1:0];
         end
         ST_START_DEC: begin
            // prod holds rx^2 * ry
            grad_y_in = {prod_ff[GW-2:0], 1'b0};
            dec_in    = (DW'(ry2_ff) << 2) - (prod_x[DW-1:0] << 2) + DW'(rx2_ff);
         end
         ST_SW_TY: begin
            tmp_in = prod_ff[MB-1:0];
         end
         ST_SW_MUL_RY: begin
            tmp_in = prod_ff[MB-1:0];
         end
         ST_SW_MUL_RX: begin
            dec_in = prod_x[DW-1:0];
         end
         ST_SW_MUL_RR: begin
            dec_in = dec_ff + (prod_x[DW-1:0] << 2);
         end
         ST_SW_DEC: begin
            dec_in   = dec_ff - (prod_x[DW-1:0] << 2);
            phase_in = PH_R2;
         end
         ST_EMIT: begin
            if (slot_free) begin
               load_point = 1'b1;
               quad_in    = quad_ff + 1'b1;
               if (quad_ff == QUAD_LAST) begin
                  use_gx_in = step_x;
                  use_gy_in = step_y;
                  if (step_x) begin
                     pos_x_in  = pos_x_ff + PXW'(1);
                     grad_x_in = grad_x_ff + GW'({ry2_ff, 1'b0});
                  end
                  if (step_y) begin
                     pos_y_in  = pos_y_ff - PXW'(1);
                     grad_y_in = grad_y_ff - GW'({rx2_ff, 1'b0});
                  end
               end
            end
         end
         ST_DONE_OUT: begin
            load_done = slot_free;
         end
         ST_ADVANCE: begin
            dec_in = dec_ff + (adv_term << 2);
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      point_x_in   = point_x_ff;
      point_y_in   = point_y_ff;
      quad_out_in  = quad_out_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      if (load_point) begin
         rsp_valid_in = 1'b1;
         point_x_in   = px_sum[OW-1:0];
         point_y_in   = py_sum[OW-1:0];
         quad_out_in  = quad_ff;
         last_in      = (quad_ff == QUAD_LAST);
         done_in      = 1'b0;
      end else if (load_done) begin
         rsp_valid_in = 1'b1;
         point_x_in   = '0;
         point_y_in   = '0;
         quad_out_in  = QUAD_FIRST;
         last_in      = 1'b1;
         done_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_DONE;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         grad_x_ff    <= '0;
         grad_y_ff    <= '0;
         dec_ff       <= '0;
         rx2_ff       <= '0;
         ry2_ff       <= '0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         quad_ff      <= QUAD_FIRST;
         use_gx_ff    <= 1'b0;
         use_gy_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         grad_x_ff    <= grad_x_in;
         grad_y_ff    <= grad_y_in;
         dec_ff       <= dec_in;
         rx2_ff       <= rx2_in;
         ry2_ff       <= ry2_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         quad_ff      <= quad_in;
         use_gx_ff    <= use_gx_in;
         use_gy_ff    <= use_gy_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tmp_ff      <= tmp_in;
      prod_ff     <= prod_in;
      point_x_ff  <= point_x_in;
      point_y_ff  <= point_y_in;
      quad_out_ff <= quad_out_in;
      last_ff     <= last_in;
      done_ff     <= done_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.point_x      = point_x_ff;
   assign rsp_chan.point_y      = point_y_ff;
   assign rsp_chan.quadrant     = quad_out_ff;
   assign rsp_chan.last_of_step = last_ff;
   assign rsp_chan.done_res     = done_ff;

endmodule

// File: src/mer_checker.sv
// port-level checks on the result channel of the ellipse rasterizer
// depends on mer_pkg and the macro header; bound to the top level below
`include "midpoint_ellipse_rasterizer_top_macros.svh"

module mer_checker import mer_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [COORD_BITS:0] point_x,
   input logic signed [COORD_BITS:0] point_y,
   input logic        [1:0]          quadrant,
   input logic                       last_of_step,
   input logic                       done_res
);

   // result offered but not taken
   logic                      stall;
   // whole result payload
   logic [2*COORD_BITS+5:0]   held;
   // shape of a finished-outline result
   logic                      done_ok;

   assign stall   = rsp_valid && !rsp_ready;
   assign held    = {point_x, point_y, quadrant, last_of_step, done_res};
   assign done_ok = last_of_step && quadrant == QUAD_FIRST && point_x == '0 && point_y == '0;

   `MER_ASSERT(a_rsp_hold, clock, reset, stall |=> rsp_valid, "result dropped while stalled")
   `MER_ASSERT(a_rsp_stable, clock, reset, stall |=> $stable(held), "stalled result changed")
   `MER_ASSERT(a_done_form, clock, reset, rsp_valid && done_res |-> done_ok, "bad done result")
   `MER_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker #(
   .COORD_BITS (COORD_BITS)
) u_mer_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .point_x      (rsp_chan.point_x),
   .point_y      (rsp_chan.point_y),
   .quadrant     (rsp_chan.quadrant),
   .last_of_step (rsp_chan.last_of_step),
   .done_res     (rsp_chan.done_res)
);
